>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define FRML_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define FRML_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/frml_pkg.sv
// ----------------------------------------------------------------------------
// frml_pkg
// Shared widths, constants, opcodes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package frml_pkg;

  localparam int WIN       = 10;
  localparam int SLOT_W    = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int CNT_W     = $clog2(WIN + 1);

  localparam int ELAPSED_W = 32;
  localparam int FREQ_W    = 32;
  localparam int FPS_W     = 10;
  localparam int FT_W      = 24;
  localparam int DELAY_W   = 10;
  localparam int RATE_W    = 26;
  localparam int SUM_W     = FT_W + CNT_W;

  localparam int SCALE_W   = 18;
  localparam int TGT_W     = 18;
  localparam int PROD_W    = ELAPSED_W + SCALE_W;
  localparam int RNUM_W    = $clog2(longint'(65536000) * WIN + 1);

  localparam logic [SCALE_W-1:0] TICK_SCALE   = 18'd256000;
  localparam logic [FT_W-1:0]    FT_MAX       = '1;
  localparam logic [RATE_W-1:0]  RATE_MAX     = 26'd65536000;
  localparam logic [RATE_W-1:0]  RATE_DEFAULT = 26'd15360;

  // shared divider
  localparam int DIV_W     = 32;
  localparam int DIV_LO_W  = 26;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] MEAS_STEPS = 5'd24;
  localparam logic [DIV_CNT_W-1:0] TGT_STEPS  = 5'd18;
  localparam logic [DIV_CNT_W-1:0] RATE_STEPS = 5'd26;

  localparam logic [1:0] OP_MEAS = 2'd0;
  localparam logic [1:0] OP_TGT  = 2'd1;
  localparam logic [1:0] OP_RATE = 2'd2;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_FREQ = 1'b0;
  localparam logic REG_FPS  = 1'b1;
  localparam logic [FREQ_W-1:0] FREQ_RST = 32'd1000000;
  localparam logic [FPS_W-1:0]  FPS_RST  = 10'd60;

  typedef struct packed {
    logic       load;
    logic       meas_sat;
    logic       div_start;
    logic [1:0] div_op;
    logic       meas_store;
    logic       tgt_store;
    logic       update;
    logic       rate_default;
    logic       rate_sat;
    logic       rate_store;
    logic       out_load;
  } frml_cmd_t;

  typedef struct packed {
    logic meas_ovf;
    logic div_done;
    logic sum_zero;
    logic rate_ovf;
    logic out_free;
  } frml_stat_t;

endpackage

>>> src/frame_rate_meter_limiter_core.sv
// ----------------------------------------------------------------------------
// frame_rate_meter_limiter_core
// Frame-end events in, per-frame delay request, recorded frame time and
// windowed frame rate out.
// ----------------------------------------------------------------------------
// Each request carries the counter ticks since the previous frame end and
// yields one result: the whole milliseconds to wait, the recorded frame time
// in 1/256 ms and the frame rate averaged over the last ten samples in 1/256
// fps. A shared one-bit-per-cycle divider produces the measured time (24
// steps), the target period (18 steps) and the average rate (26 steps); the
// measured-time or rate division is skipped when it would saturate, and the
// rate division also when the window sum is zero. One request is in flight
// at a time; the next is taken while the previous result still waits in the
// output register.
// Configuration: counter frequency at 0x0, frame rate cap at 0x4.
module frame_rate_meter_limiter_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [frml_pkg::ELAPSED_W-1:0]     in_frame_elapsed,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [frml_pkg::DELAY_W-1:0]       out_delay_ms,
  output logic [frml_pkg::FT_W-1:0]          out_frame_time,
  output logic [frml_pkg::RATE_W-1:0]        out_frame_rate,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [frml_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [frml_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [frml_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  frml_pkg::frml_cmd_t           cmd;
  frml_pkg::frml_stat_t          stat;
  logic [frml_pkg::FREQ_W-1:0]   counter_freq;
  logic [frml_pkg::FPS_W-1:0]    max_fps;

  frml_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .counter_freq (counter_freq),
    .max_fps      (max_fps)
  );

  frml_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  frml_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .counter_freq     (counter_freq),
    .max_fps          (max_fps),
    .in_frame_elapsed (in_frame_elapsed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_delay_ms     (out_delay_ms),
    .out_frame_time   (out_frame_time),
    .out_frame_rate   (out_frame_rate)
  );

endmodule

>>> src/frml_cfg.sv
// ----------------------------------------------------------------------------
// frml_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module frml_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [frml_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [frml_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [frml_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready,
  output logic [frml_pkg::FREQ_W-1:0]        counter_freq,
  output logic [frml_pkg::FPS_W-1:0]         max_fps
);

  logic [frml_pkg::FREQ_W-1:0] freq_r;
  logic [frml_pkg::FPS_W-1:0]  fps_r;
  logic                        wr_en;
  logic                        reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= frml_pkg::FREQ_RST;
      fps_r  <= frml_pkg::FPS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        frml_pkg::REG_FREQ: freq_r <= cfg_pwdata;
        frml_pkg::REG_FPS:  fps_r  <= cfg_pwdata[frml_pkg::FPS_W-1:0];
        default:            freq_r <= freq_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      frml_pkg::REG_FREQ: cfg_prdata = freq_r;
      frml_pkg::REG_FPS:  cfg_prdata = frml_pkg::CFG_DATA_W'(fps_r);
      default:            cfg_prdata = '0;
    endcase
  end

  assign counter_freq = freq_r;
  assign max_fps      = fps_r;

endmodule

>>> src/frml_div.sv
// ----------------------------------------------------------------------------
// frml_div
// Restoring divider, one quotient bit per cycle. The caller loads the
// partial remainder (already below the divisor) and the remaining dividend
// bits left-aligned, plus the number of quotient bits to produce.
// ----------------------------------------------------------------------------
module frml_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [frml_pkg::DIV_W-1:0]        rem_init,
  input  logic [frml_pkg::DIV_LO_W-1:0]     lo_init,
  input  logic [frml_pkg::DIV_W-1:0]        den,
  input  logic [frml_pkg::DIV_CNT_W-1:0]    steps,
  output logic                              done,
  output logic [frml_pkg::DIV_LO_W-1:0]     quot
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [frml_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [frml_pkg::DIV_W-1:0]        rem_r, rem_nxt;
  logic [frml_pkg::DIV_LO_W-1:0]     lo_r, lo_nxt;
  logic [frml_pkg::DIV_W-1:0]        den_r, den_nxt;
  logic [frml_pkg::DIV_LO_W-1:0]     q_r, q_nxt;
  logic [frml_pkg::DIV_W:0]          trial;
  logic [frml_pkg::DIV_W:0]          diff;
  logic                              ge;

  assign trial = {rem_r, lo_r[frml_pkg::DIV_LO_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      rem_nxt  = rem_init;
      lo_nxt   = lo_init;
      den_nxt  = den;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[frml_pkg::DIV_W-1:0] : trial[frml_pkg::DIV_W-1:0];
      lo_nxt  = {lo_r[frml_pkg::DIV_LO_W-2:0], 1'b0};
      q_nxt   = {q_r[frml_pkg::DIV_LO_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == frml_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> src/frml_ctrl.sv
// ----------------------------------------------------------------------------
// frml_ctrl
// Sequencer: measured time, target period, window update, average rate,
// result hand-off.
// ----------------------------------------------------------------------------
module frml_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  frml_pkg::frml_stat_t  stat,
  output frml_pkg::frml_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MSTART = 4'd1;
  localparam logic [3:0] S_MWAIT  = 4'd2;
  localparam logic [3:0] S_TSTART = 4'd3;
  localparam logic [3:0] S_TWAIT  = 4'd4;
  localparam logic [3:0] S_UPD    = 4'd5;
  localparam logic [3:0] S_RSTART = 4'd6;
  localparam logic [3:0] S_RWAIT  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MSTART;
        end
      end
      S_MSTART: begin
        if (stat.meas_ovf) begin
          cmd.meas_sat = 1'b1;
          state_nxt    = S_TSTART;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = frml_pkg::OP_MEAS;
          state_nxt     = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (stat.div_done) begin
          cmd.meas_store = 1'b1;
          state_nxt      = S_TSTART;
        end
      end
      S_TSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = frml_pkg::OP_TGT;
        state_nxt     = S_TWAIT;
      end
      S_TWAIT: begin
        if (stat.div_done) begin
          cmd.tgt_store = 1'b1;
          state_nxt     = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_RSTART;
      end
      S_RSTART: begin
        priority if (stat.sum_zero) begin
          cmd.rate_default = 1'b1;
          state_nxt        = S_OUT;
        end else if (stat.rate_ovf) begin
          cmd.rate_sat = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = frml_pkg::OP_RATE;
          state_nxt     = S_RWAIT;
        end
      end
      S_RWAIT: begin
        if (stat.div_done) begin
          cmd.rate_store = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/frml_dp.sv
// ----------------------------------------------------------------------------
// frml_dp
// Datapath: tick scaling, shared divider, delay and sample, sample window,
// rate and the output register.
// ----------------------------------------------------------------------------
module frml_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  frml_pkg::frml_cmd_t               cmd,
  output frml_pkg::frml_stat_t              stat,
  input  logic [frml_pkg::FREQ_W-1:0]       counter_freq,
  input  logic [frml_pkg::FPS_W-1:0]        max_fps,
  input  logic [frml_pkg::ELAPSED_W-1:0]    in_frame_elapsed,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [frml_pkg::DELAY_W-1:0]      out_delay_ms,
  output logic [frml_pkg::FT_W-1:0]         out_frame_time,
  output logic [frml_pkg::RATE_W-1:0]       out_frame_rate
);

  localparam int RCMP_W = frml_pkg::SUM_W + frml_pkg::RATE_W;
  localparam int MCMP_W = frml_pkg::FREQ_W + frml_pkg::FT_W;
  localparam int RX_W   = frml_pkg::DIV_W + frml_pkg::DIV_LO_W;

  logic [frml_pkg::PROD_W-1:0]    prod_r;
  logic [frml_pkg::FT_W-1:0]      meas_r;
  logic [frml_pkg::TGT_W-1:0]     tgt_r;
  logic [frml_pkg::DELAY_W-1:0]   delay_r;
  logic [frml_pkg::FT_W-1:0]      sample_r;
  logic [frml_pkg::RATE_W-1:0]    rate_r;
  logic [frml_pkg::RNUM_W-1:0]    rnum_r;
  logic [frml_pkg::FT_W-1:0]      ring_r [frml_pkg::WIN];
  logic [frml_pkg::FT_W-1:0]      old_r;
  logic [frml_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic [frml_pkg::CNT_W-1:0]     filled_r, filled_nxt;
  logic [frml_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic                           out_valid_r;
  logic [frml_pkg::DELAY_W-1:0]   out_delay_r;
  logic [frml_pkg::FT_W-1:0]      out_ft_r;
  logic [frml_pkg::RATE_W-1:0]    out_rate_r;

  logic [frml_pkg::FREQ_W-1:0]    freq_eff;
  logic [frml_pkg::FPS_W-1:0]     fps_eff;
  logic [frml_pkg::PROD_W-1:0]    prod_nxt;
  logic                           short_frame;
  logic [frml_pkg::TGT_W-1:0]     gap;
  logic [frml_pkg::DELAY_W-1:0]   delay_nxt;
  logic [frml_pkg::FT_W-1:0]      sample_nxt;
  logic                           full;
  logic [frml_pkg::FT_W-1:0]      old_sample;
  logic [frml_pkg::RNUM_W-1:0]    rnum_nxt;
  logic [RX_W-1:0]                rnum_ext;
  logic [frml_pkg::RATE_W-1:0]    rate_q;

  logic                           div_done;
  logic [frml_pkg::DIV_LO_W-1:0]  div_quot;
  logic [frml_pkg::DIV_W-1:0]     div_rem0;
  logic [frml_pkg::DIV_LO_W-1:0]  div_lo0;
  logic [frml_pkg::DIV_W-1:0]     div_den;
  logic [frml_pkg::DIV_CNT_W-1:0] div_steps;

  assign freq_eff = (counter_freq == '0) ? frml_pkg::FREQ_W'(1) : counter_freq;
  assign fps_eff  = (max_fps == '0) ? frml_pkg::FPS_W'(1) : max_fps;
  assign prod_nxt = frml_pkg::PROD_W'(in_frame_elapsed) *
                    frml_pkg::PROD_W'(frml_pkg::TICK_SCALE);
  assign rnum_ext = RX_W'(rnum_r);

  always_comb begin
    unique case (cmd.div_op)
      frml_pkg::OP_MEAS: begin
        div_rem0  = frml_pkg::DIV_W'(prod_r[frml_pkg::PROD_W-1:frml_pkg::FT_W]);
        div_lo0   = {prod_r[frml_pkg::FT_W-1:0],
                     (frml_pkg::DIV_LO_W - frml_pkg::FT_W)'(0)};
        div_den   = freq_eff;
        div_steps = frml_pkg::MEAS_STEPS;
      end
      frml_pkg::OP_TGT: begin
        div_rem0  = '0;
        div_lo0   = {frml_pkg::TICK_SCALE,
                     (frml_pkg::DIV_LO_W - frml_pkg::SCALE_W)'(0)};
        div_den   = frml_pkg::DIV_W'(fps_eff);
        div_steps = frml_pkg::TGT_STEPS;
      end
      frml_pkg::OP_RATE: begin
        div_rem0  = rnum_ext[RX_W-1:frml_pkg::DIV_LO_W];
        div_lo0   = rnum_ext[frml_pkg::DIV_LO_W-1:0];
        div_den   = frml_pkg::DIV_W'(sum_r);
        div_steps = frml_pkg::RATE_STEPS;
      end
      default: begin
        div_rem0  = '0;
        div_lo0   = '0;
        div_den   = frml_pkg::DIV_W'(1);
        div_steps = frml_pkg::DIV_CNT_W'(1);
      end
    endcase
  end

  frml_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .rem_init (div_rem0),
    .lo_init  (div_lo0),
    .den      (div_den),
    .steps    (div_steps),
    .done     (div_done),
    .quot     (div_quot)
  );

  // delay and recorded sample
  assign short_frame = frml_pkg::FT_W'(tgt_r) > meas_r;
  assign gap         = tgt_r - meas_r[frml_pkg::TGT_W-1:0];
  assign delay_nxt   = short_frame ? gap[frml_pkg::TGT_W-1:8] : '0;
  assign sample_nxt  = short_frame ?
                       meas_r + frml_pkg::FT_W'({gap[frml_pkg::TGT_W-1:8], 8'd0}) :
                       meas_r;

  // window bookkeeping
  assign full       = filled_r == frml_pkg::CNT_W'(frml_pkg::WIN);
  assign old_sample = full ? old_r : '0;
  assign sum_nxt    = sum_r - frml_pkg::SUM_W'(old_sample) +
                      frml_pkg::SUM_W'(sample_nxt);
  assign filled_nxt = full ? filled_r : filled_r + 1'b1;
  assign slot_nxt   = (slot_r == frml_pkg::SLOT_W'(frml_pkg::WIN - 1)) ?
                      '0 : slot_r + 1'b1;
  assign rnum_nxt   = frml_pkg::RNUM_W'(frml_pkg::RNUM_W'(frml_pkg::RATE_MAX) *
                                        frml_pkg::RNUM_W'(filled_nxt));

  assign rate_q = (div_quot > frml_pkg::RATE_MAX) ? frml_pkg::RATE_MAX : div_quot;

  assign stat.meas_ovf = MCMP_W'(prod_r) >= {freq_eff, frml_pkg::FT_W'(0)};
  assign stat.div_done = div_done;
  assign stat.sum_zero = sum_r == '0;
  assign stat.rate_ovf = RCMP_W'(rnum_r) >= {sum_r, frml_pkg::RATE_W'(0)};
  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      filled_r    <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        slot_r   <= slot_nxt;
        filled_r <= filled_nxt;
        sum_r    <= sum_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod_r <= prod_nxt;
      old_r  <= ring_r[slot_r];
    end
    if (cmd.meas_sat) begin
      meas_r <= frml_pkg::FT_MAX;
    end else if (cmd.meas_store) begin
      meas_r <= div_quot[frml_pkg::FT_W-1:0];
    end
    if (cmd.tgt_store) begin
      tgt_r <= div_quot[frml_pkg::TGT_W-1:0];
    end
    if (cmd.update) begin
      delay_r        <= delay_nxt;
      sample_r       <= sample_nxt;
      rnum_r         <= rnum_nxt;
      ring_r[slot_r] <= sample_nxt;
    end
    if (cmd.rate_default) begin
      rate_r <= frml_pkg::RATE_DEFAULT;
    end else if (cmd.rate_sat) begin
      rate_r <= frml_pkg::RATE_MAX;
    end else if (cmd.rate_store) begin
      rate_r <= rate_q;
    end
    if (cmd.out_load) begin
      out_delay_r <= delay_r;
      out_ft_r    <= sample_r;
      out_rate_r  <= rate_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_delay_ms   = out_delay_r;
  assign out_frame_time = out_ft_r;
  assign out_frame_rate = out_rate_r;

endmodule

>>> src/frml_checker.sv
// ----------------------------------------------------------------------------
// frml_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frml_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [frml_pkg::DELAY_W-1:0]    out_delay_ms,
  input logic [frml_pkg::FT_W-1:0]       out_frame_time,
  input logic [frml_pkg::RATE_W-1:0]     out_frame_rate
);

  `FRML_ASSERT_RST(a_rst_clears_out, clk, !rst_n |=> !out_valid, "result valid after reset")

  `FRML_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_frame_rate) && $stable(out_frame_time) && $stable(out_delay_ms), "stalled result changed")

  `FRML_ASSERT(a_rate_range, clk, rst_n, out_valid |-> out_frame_rate <= frml_pkg::RATE_MAX, "frame rate above ceiling")

  `FRML_ASSERT(a_delay_short, clk, rst_n, out_valid && out_delay_ms != '0 |-> out_delay_ms <= 10'd1000 && out_frame_time <= 24'd256000, "delay on a long frame")

endmodule

bind frame_rate_meter_limiter_core frml_checker u_frml_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_delay_ms   (out_delay_ms),
  .out_frame_time (out_frame_time),
  .out_frame_rate (out_frame_rate)
);

>>> tb/frame_rate_meter_limiter_core_tb.sv
// ----------------------------------------------------------------------------
// frame_rate_meter_limiter_core_tb
// Feeds frame-end requests through the valid/stall channel and checks every
// delay, frame time and windowed rate against an in-bench model of the tick
// conversion, delay rounding and ten-sample average. Directed corner frames
// come first, then random frames over several clock and cap settings, with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module frame_rate_meter_limiter_core_tb;
  import frml_pkg::*;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_ms;
    logic [FT_W-1:0]    frame_time;
    logic [RATE_W-1:0]  frame_rate;
  } frame_result_t;

  class frame_meter_sb;
    logic [FREQ_W-1:0] freq;
    logic [FPS_W-1:0]  fps;
    logic [FT_W-1:0]   ring [WIN];
    int unsigned       slot;
    int unsigned       filled;
    logic [63:0]       window_total;
    frame_result_t     awaited [$];
    int unsigned       mismatches;

    function new();
      freq = FREQ_RST;
      fps = FPS_RST;
      slot = 0;
      filled = 0;
      window_total = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic reg_sel, logic [CFG_DATA_W-1:0] value);
      if (reg_sel == REG_FREQ) begin
        freq = value;
      end else begin
        fps = value[FPS_W-1:0];
      end
    endfunction

    function void note_frame(logic [ELAPSED_W-1:0] elapsed);
      logic [63:0] f, cap, meas, tgt, dly, smp, rate;
      frame_result_t r;
      f = (freq == 0) ? 64'd1 : 64'(freq);
      cap = (fps == 0) ? 64'd1 : 64'(fps);
      meas = (64'(elapsed) * 64'(TICK_SCALE)) / f;
      tgt = 64'(TICK_SCALE) / cap;
      dly = (meas < tgt) ? (tgt - meas) / 256 : 64'd0;
      smp = meas + dly * 256;
      if (smp > 64'(FT_MAX)) smp = 64'(FT_MAX);
      if (filled >= WIN) begin
        window_total -= 64'(ring[slot]);
      end else begin
        filled++;
      end
      ring[slot] = smp[FT_W-1:0];
      window_total += smp;
      slot = (slot + 1) % WIN;
      if (window_total == 0) begin
        rate = 64'(RATE_DEFAULT);
      end else begin
        rate = (64'(RATE_MAX) * filled) / window_total;
        if (rate > 64'(RATE_MAX)) rate = 64'(RATE_MAX);
      end
      r.delay_ms = dly[DELAY_W-1:0];
      r.frame_time = smp[FT_W-1:0];
      r.frame_rate = rate[RATE_W-1:0];
      awaited.push_back(r);
    endfunction

    function void report(string what, frame_result_t want, frame_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: want delay %0d time %0d rate %0d, got delay %0d time %0d rate %0d",
                 what, want.delay_ms, want.frame_time, want.frame_rate,
                 got.delay_ms, got.frame_time, got.frame_rate);
    endfunction

    function void check_result(logic [DELAY_W-1:0] d, logic [FT_W-1:0] t,
                               logic [RATE_W-1:0] r);
      frame_result_t got, want;
      got.delay_ms = d;
      got.frame_time = t;
      got.frame_rate = r;
      if (awaited.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = awaited.pop_front();
      if (got.delay_ms !== want.delay_ms || got.frame_time !== want.frame_time ||
          got.frame_rate !== want.frame_rate)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ELAPSED_W-1:0]  in_frame_elapsed = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DELAY_W-1:0]    out_delay_ms;
  logic [FT_W-1:0]       out_frame_time;
  logic [RATE_W-1:0]     out_frame_rate;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  frame_meter_sb sb = new();
  bit feeding = 1'b0;
  bit steady_in = 1'b0;
  bit steady_out = 1'b0;

  frame_rate_meter_limiter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_elapsed (in_frame_elapsed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_delay_ms     (out_delay_ms),
    .out_frame_time   (out_frame_time),
    .out_frame_rate   (out_frame_rate),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_delay_ms, out_frame_time, out_frame_rate);
  end

  // result side back-pressure, one draw per result
  initial begin
    int n;
    forever begin
      if ($urandom_range(0, 39) == 0) steady_out = !steady_out;
      n = steady_out ? 0 : $urandom_range(0, 13);
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_frame(logic [ELAPSED_W-1:0] elapsed);
    int gap;
    if ($urandom_range(0, 39) == 0) steady_in = !steady_in;
    gap = steady_in ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      if (feeding) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_elapsed <= elapsed;
    feeding = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_frame(elapsed);
  endtask

  task automatic pause_input();
    if (feeding) begin
      in_valid <= 1'b0;
      feeding = 1'b0;
    end
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // leaves psel/penable high so a second transfer can follow directly
  task automatic cfg_write(logic reg_sel, logic [CFG_DATA_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_sel, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(reg_sel, value);
  endtask

  task automatic set_config(logic [FREQ_W-1:0] freq, logic [FPS_W-1:0] fps);
    pause_input();
    cfg_write(REG_FREQ, freq);
    cfg_write(REG_FPS, CFG_DATA_W'(fps));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic send_all(logic [ELAPSED_W-1:0] list [$]);
    foreach (list[i]) send_frame(list[i]);
  endtask

  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    logic [63:0] ticks, f, cap;
    f = 64'(sb.freq);
    cap = (sb.fps == 0) ? 64'd1 : 64'(sb.fps);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: ticks = f * $urandom_range(0, 40000) / 1000000;
      5, 6: ticks = f * $urandom_range(0, 2000) / (1000 * cap);
      7: ticks = $urandom_range(0, 255);
      default: ticks = $urandom;
    endcase
    return (ticks > 64'hFFFF_FFFF) ? '1 : ticks[ELAPSED_W-1:0];
  endfunction

  task automatic run_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 249) == 0) pause_input();
      send_frame(pick_elapsed());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // zero-sum window, then a tiny average that saturates the rate
    set_config(32'd256000, 10'd1023);
    send_all('{32'd0, 32'd0, 32'd1, 32'd0});
    set_config(FREQ_RST, FPS_RST);
    send_all('{32'd0, 32'd1, 32'd16666, 32'd16667, 32'd16680, 32'd33333,
               32'd1000000, 32'hFFFF_FFFF});
    // zero clock and zero cap
    set_config(32'd0, 10'd0);
    send_all('{32'd0, 32'd1, 32'hFFFF_FFFF});
    set_config(32'hFFFF_FFFF, 10'd1000);
    send_all('{32'd0, 32'hFFFF_FFFF});
    set_config(32'd1000, 10'd1);
    send_all('{32'hFFFF_FFFF, 32'd1000});

    set_config(FREQ_RST, FPS_RST);
    run_random(150);
    pause_input();
    run_random(150);
    set_config(32'd1000, 10'd1);
    run_random(150);
    set_config(32'hFFFF_FFFF, 10'd1000);
    run_random(150);
    set_config(32'd0, 10'd1023);
    run_random(150);
    for (int p = 0; p < 6; p++) begin
      set_config($urandom_range(0, 1) ? $urandom : $urandom_range(1000, 100000000),
                 10'($urandom_range(0, 1023)));
      run_random(150);
    end

    pause_input();
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("frame_rate_meter_limiter_core_tb: done, clean");
    end else begin
      $display("frame_rate_meter_limiter_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #9600000;
    $display("frame_rate_meter_limiter_core_tb: done, errors");
    $finish;
  end

endmodule

>>> frame_rate_meter_limiter_core.f
+incdir+src
src/frml_pkg.sv
src/frml_cfg.sv
src/frml_div.sv
src/frml_ctrl.sv
src/frml_dp.sv
src/frame_rate_meter_limiter_core.sv
src/frml_checker.sv
tb/frame_rate_meter_limiter_core_tb.sv
